@@ design/bfiq_pkg.sv @@
`default_nettype none
package bfiq_pkg;

  localparam int unsigned MAX_FILTER_BITS = 2097152;
  localparam int unsigned NUM_HASHES = 10;

  localparam int unsigned CFG_W = 22;
  localparam logic [CFG_W-1:0] FILTER_BITS_RESET = 22'd1500000;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  // The FNV prime is 2^40 + 0x1b3, so the multiply is a shift and a narrow product.
  localparam int unsigned FNV_SHIFT = 40;
  localparam logic [63:0] FNV_LOW = 64'h00000000000001b3;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [31:0] GOLDEN_STEP = 32'h9e3779b9;
  localparam int unsigned MIX_SHIFT = 33;

  localparam int unsigned DIV_STEP = 2;
  localparam int unsigned DIV_CYCLES = 64 / DIV_STEP;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_CYCLES);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;
  localparam logic [QCNT_W-1:0] QUEUE_FULL = 2'd2;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    logic [63:0] hash;
    op_t         op;
  } key_entry_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_SEED,
    B_MUL,
    B_POS,
    B_DIV,
    B_READ,
    B_CHECK,
    B_DONE
  } back_state_t;

  typedef enum logic [1:0] {
    MPH_LOW,
    MPH_CROSS_HI,
    MPH_CROSS_LO
  } mul_phase_t;

  typedef enum logic {
    MIX_FIRST,
    MIX_SECOND
  } mix_sel_t;

  function automatic logic [63:0] xor_shift(input logic [63:0] x);
    return x ^ (x >> MIX_SHIFT);
  endfunction

  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] y;
    y = h ^ {56'd0, b};
    return (y << FNV_SHIFT) + (y * FNV_LOW);
  endfunction

endpackage
`default_nettype wire

@@ design/bfiq_if.sv @@
`default_nettype none
interface bfiq_key_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] key_byte;
  logic       last_byte;
  modport source(output valid, op, key_byte, last_byte, input ready);
  modport sink(input valid, op, key_byte, last_byte, output ready);
endinterface

interface bfiq_result_if;
  logic valid;
  logic ready;
  logic probably_present;
  logic was_add;
  modport source(output valid, probably_present, was_add, input ready);
  modport sink(input valid, probably_present, was_add, output ready);
endinterface

interface bfiq_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [bfiq_pkg::CFG_W-1:0]   filter_bit_count;
  modport source(output valid, filter_bit_count, input ready);
  modport sink(input valid, filter_bit_count, output ready);
endinterface
`default_nettype wire

@@ design/bfiq_front.sv @@
`default_nettype none
module bfiq_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  bfiq_key_if.sink                  key_in,
  input  wire logic                 clearing,
  output logic                      push_valid,
  output bfiq_pkg::key_entry_t      push_entry,
  input  wire logic                 push_ready
);

  logic [63:0] hash;
  logic [63:0] hash_next;
  logic        take;

  assign key_in.ready = !clearing && push_ready;
  assign take = key_in.valid && key_in.ready;
  assign hash_next = bfiq_pkg::fnv_step(hash, key_in.key_byte);

  assign push_valid = take && key_in.last_byte;
  assign push_entry.hash = hash_next;
  assign push_entry.op = bfiq_pkg::op_t'(key_in.op);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= bfiq_pkg::FNV_BASIS;
    end else if (take) begin
      hash <= key_in.last_byte ? bfiq_pkg::FNV_BASIS : hash_next;
    end
  end

endmodule
`default_nettype wire

@@ design/bfiq_queue.sv @@
`default_nettype none
module bfiq_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push_valid,
  input  wire bfiq_pkg::key_entry_t push_entry,
  output logic                      push_ready,
  output logic                      pop_valid,
  output bfiq_pkg::key_entry_t      pop_entry,
  input  wire logic                 pop_ready
);

  bfiq_pkg::key_entry_t               slots [bfiq_pkg::QUEUE_DEPTH];
  logic [bfiq_pkg::QPTR_W-1:0]        wr_ptr;
  logic [bfiq_pkg::QPTR_W-1:0]        rd_ptr;
  logic [bfiq_pkg::QCNT_W-1:0]        count;
  logic                               do_push;
  logic                               do_pop;

  assign push_ready = count != bfiq_pkg::QUEUE_FULL;
  assign pop_valid = count != '0;
  assign pop_entry = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/bfiq_back.sv @@
`default_nettype none
module bfiq_back #(
  parameter int unsigned MAX_FILTER_BITS = bfiq_pkg::MAX_FILTER_BITS,
  parameter int unsigned NUM_HASHES = bfiq_pkg::NUM_HASHES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  bfiq_cfg_if.sink                  cfg,
  bfiq_result_if.source             result,
  input  wire logic                 pop_valid,
  input  wire bfiq_pkg::key_entry_t pop_entry,
  output logic                      pop_ready,
  output logic                      clearing
);

  localparam int unsigned MW = $clog2(MAX_FILTER_BITS + 1);
  localparam int unsigned CW = (MW > bfiq_pkg::CFG_W) ? MW : bfiq_pkg::CFG_W;
  localparam int unsigned ROWS = (MAX_FILTER_BITS + 7) / 8;
  localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned IW = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
  localparam logic [CW-1:0] M_MIN = CW'(8);
  localparam logic [CW-1:0] M_MAX = CW'(MAX_FILTER_BITS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_HASHES - 1);
  localparam logic [bfiq_pkg::DIV_CNT_W-1:0] LAST_DIV = bfiq_pkg::DIV_CNT_W'(bfiq_pkg::DIV_CYCLES - 1);

  bfiq_pkg::back_state_t state;
  bfiq_pkg::back_state_t state_next;

  logic [bfiq_pkg::CFG_W-1:0]     filter_bit_count;
  logic [63:0]                    h1;
  bfiq_pkg::op_t                  op;
  logic [IW-1:0]                  idx;
  logic                           present;
  logic [63:0]                    x;
  logic [63:0]                    acc;
  bfiq_pkg::mix_sel_t             mix_sel;
  bfiq_pkg::mul_phase_t           mph;
  logic [63:0]                    num;
  logic [MW:0]                    rem;
  logic [bfiq_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [RW-1:0]                  clr_row;
  logic [7:0]                     rd_data;
  logic                           out_valid;
  logic                           out_present;
  logic                           out_add;
  logic [7:0]                     mem [ROWS];

  logic [CW-1:0]  cnt_ext;
  logic [CW-1:0]  m_full;
  logic [MW-1:0]  modulus;
  logic [63:0]    mul_const;
  logic [31:0]    mul_a;
  logic [31:0]    mul_b;
  logic [63:0]    mul_p;
  logic [63:0]    mul_sum;
  logic [MW:0]    rem_next;
  logic [63:0]    num_next;
  logic [RW-1:0]  row;
  logic [2:0]     bit_sel;
  logic           out_free;
  logic           mem_we;
  logic [RW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;

  assign cfg.ready = 1'b1;
  assign result.valid = out_valid;
  assign result.probably_present = out_present;
  assign result.was_add = out_add;
  assign pop_ready = state == bfiq_pkg::B_IDLE;
  assign clearing = state == bfiq_pkg::B_CLEAR;
  assign out_free = !out_valid || result.ready;

  always_comb begin
    cnt_ext = CW'(filter_bit_count);
    if (cnt_ext < M_MIN) begin
      m_full = M_MIN;
    end else if (cnt_ext > M_MAX) begin
      m_full = M_MAX;
    end else begin
      m_full = cnt_ext;
    end
    modulus = MW'(m_full);
  end

  always_comb begin
    mul_const = (mix_sel == bfiq_pkg::MIX_SECOND) ? bfiq_pkg::MIX_C2 : bfiq_pkg::MIX_C1;
    case (mph)
      bfiq_pkg::MPH_CROSS_HI: begin
        mul_a = x[63:32];
        mul_b = mul_const[31:0];
      end
      bfiq_pkg::MPH_CROSS_LO: begin
        mul_a = x[31:0];
        mul_b = mul_const[63:32];
      end
      default: begin
        mul_a = x[31:0];
        mul_b = mul_const[31:0];
      end
    endcase
    mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    mul_sum = acc + {mul_p[31:0], 32'd0};
  end

  // Restoring remainder, DIV_STEP dividend bits per cycle.
  always_comb begin
    logic [MW:0] r_sh;
    rem_next = rem;
    num_next = num;
    for (int k = 0; k < bfiq_pkg::DIV_STEP; k++) begin
      r_sh = {rem_next[MW-1:0], num_next[63]};
      num_next = num_next << 1;
      if (r_sh >= {1'b0, modulus}) begin
        rem_next = r_sh - {1'b0, modulus};
      end else begin
        rem_next = r_sh;
      end
    end
  end

  assign row = RW'(rem >> 3);
  assign bit_sel = rem[2:0];

  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    mem_waddr = row;
    mem_wdata = rd_data | (8'd1 << bit_sel);
    unique case (state)
      bfiq_pkg::B_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_row;
        mem_wdata = '0;
        if (clr_row == LAST_ROW) begin
          state_next = bfiq_pkg::B_IDLE;
        end
      end
      bfiq_pkg::B_IDLE: begin
        if (pop_valid) begin
          state_next = bfiq_pkg::B_SEED;
        end
      end
      bfiq_pkg::B_SEED: begin
        state_next = bfiq_pkg::B_MUL;
      end
      bfiq_pkg::B_MUL: begin
        if (mph == bfiq_pkg::MPH_CROSS_LO && mix_sel == bfiq_pkg::MIX_SECOND) begin
          state_next = bfiq_pkg::B_POS;
        end
      end
      bfiq_pkg::B_POS: begin
        state_next = bfiq_pkg::B_DIV;
      end
      bfiq_pkg::B_DIV: begin
        if (div_cnt == LAST_DIV) begin
          state_next = bfiq_pkg::B_READ;
        end
      end
      bfiq_pkg::B_READ: begin
        state_next = bfiq_pkg::B_CHECK;
      end
      bfiq_pkg::B_CHECK: begin
        mem_we = op == bfiq_pkg::OP_ADD;
        state_next = (idx == LAST_IDX) ? bfiq_pkg::B_DONE : bfiq_pkg::B_SEED;
      end
      bfiq_pkg::B_DONE: begin
        if (out_free) begin
          state_next = bfiq_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = bfiq_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfiq_pkg::B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_bit_count <= bfiq_pkg::FILTER_BITS_RESET;
      clr_row <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        filter_bit_count <= cfg.filter_bit_count;
      end
      if (state == bfiq_pkg::B_CLEAR) begin
        clr_row <= clr_row + 1'b1;
      end
      if (state == bfiq_pkg::B_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      bfiq_pkg::B_IDLE: begin
        h1 <= pop_entry.hash;
        op <= pop_entry.op;
        idx <= '0;
        present <= 1'b1;
      end
      bfiq_pkg::B_SEED: begin
        x <= bfiq_pkg::xor_shift(h1 + ({{(64 - IW){1'b0}}, idx} * {32'd0, bfiq_pkg::GOLDEN_STEP}));
        mix_sel <= bfiq_pkg::MIX_FIRST;
        mph <= bfiq_pkg::MPH_LOW;
      end
      bfiq_pkg::B_MUL: begin
        case (mph)
          bfiq_pkg::MPH_LOW: begin
            acc <= mul_p;
            mph <= bfiq_pkg::MPH_CROSS_HI;
          end
          bfiq_pkg::MPH_CROSS_HI: begin
            acc <= mul_sum;
            mph <= bfiq_pkg::MPH_CROSS_LO;
          end
          default: begin
            x <= bfiq_pkg::xor_shift(mul_sum);
            mix_sel <= bfiq_pkg::MIX_SECOND;
            mph <= bfiq_pkg::MPH_LOW;
          end
        endcase
      end
      bfiq_pkg::B_POS: begin
        num <= h1 + ({{(64 - IW){1'b0}}, idx} * x);
        rem <= '0;
        div_cnt <= '0;
      end
      bfiq_pkg::B_DIV: begin
        num <= num_next;
        rem <= rem_next;
        div_cnt <= div_cnt + 1'b1;
      end
      bfiq_pkg::B_CHECK: begin
        if (op == bfiq_pkg::OP_QUERY && !rd_data[bit_sel]) begin
          present <= 1'b0;
        end
        idx <= idx + 1'b1;
      end
      bfiq_pkg::B_DONE: begin
        if (out_free) begin
          out_present <= op == bfiq_pkg::OP_QUERY && present;
          out_add <= op == bfiq_pkg::OP_ADD;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ design/bloom_filter_insert_query.sv @@
// Key words are taken one per cycle while the queue has room and no clear runs; a key's hash
// is ready the cycle its last word is taken. Each key is then probed once per hash: a seed,
// each mix step's 32x32 product in phases (low, cross high, cross low), the remainder loop,
// a table read and a check. A two-entry key queue lets the next keys stream in while one
// key is probed. Reset (synchronous, rst high) zeroes the filter one byte row per cycle over
// its (MAX_FILTER_BITS + 7) / 8 rows (262144 by default); no key word is taken until done.
`default_nettype none
module bloom_filter_insert_query #(
  parameter int unsigned MAX_FILTER_BITS = bfiq_pkg::MAX_FILTER_BITS,
  parameter int unsigned NUM_HASHES = bfiq_pkg::NUM_HASHES
) (
  input  wire logic     clk,
  input  wire logic     rst,
  bfiq_key_if.sink      key_in,
  bfiq_result_if.source result,
  bfiq_cfg_if.sink      cfg
);

  logic                 push_valid;
  logic                 push_ready;
  bfiq_pkg::key_entry_t push_entry;
  logic                 pop_valid;
  logic                 pop_ready;
  bfiq_pkg::key_entry_t pop_entry;
  logic                 clearing;

  bfiq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .key_in     (key_in),
    .clearing   (clearing),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  bfiq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  bfiq_back #(
    .MAX_FILTER_BITS (MAX_FILTER_BITS),
    .NUM_HASHES      (NUM_HASHES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .result    (result),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop_ready (pop_ready),
    .clearing  (clearing)
  );

endmodule
`default_nettype wire

@@ design/bfiq_checker.sv @@
`default_nettype none
module bfiq_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic probably_present,
  input wire logic was_add
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("key input ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  a_add_not_present: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_add |-> !probably_present)
    else $error("add result reports present");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid)
    else $error("result words closer than one key's probe time");

endmodule

bind bloom_filter_insert_query bfiq_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (key_in.valid),
  .in_ready         (key_in.ready),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .probably_present (result.probably_present),
  .was_add          (result.was_add)
);
`default_nettype wire
